@@ src/i2c_rm_pkg.sv @@
// package for the i2c register master: commands, phases, constants
`default_nettype none
package i2c_rm_pkg;
	localparam int unsigned DELAY_W = 16;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd10;

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_WRITE = 3'd1,
		CMD_RD1   = 3'd2,
		CMD_RD2   = 3'd3,
		CMD_RD6   = 3'd4
	} cmd_t;

	typedef enum logic [4:0] {
		PH_IDLE = 5'd0,
		PH_ST0 = 5'd1, PH_ST1 = 5'd2, PH_ST2 = 5'd3, PH_ST3 = 5'd4,
		PH_ST4 = 5'd5, PH_ST5 = 5'd6, PH_ST6 = 5'd7, PH_ST7 = 5'd8,
		PH_TXL = 5'd9, PH_TXH = 5'd10,
		PH_TA0 = 5'd11, PH_TA1 = 5'd12, PH_TA2 = 5'd13,
		PH_RXL = 5'd14, PH_RXH = 5'd15,
		PH_MA0 = 5'd16, PH_MA1 = 5'd17, PH_MA2 = 5'd18, PH_MA3 = 5'd19,
		PH_SP0 = 5'd20, PH_SP1 = 5'd21, PH_SP2 = 5'd22, PH_SP3 = 5'd23,
		PH_SP4 = 5'd24, PH_SP5 = 5'd25
	} phase_t;
endpackage
`default_nettype wire

@@ src/i2c_register_master_top.sv @@
// i2c register master: tick-driven bus sequencer with registered result
//
// usage: the input channel (in_valid/in_ready) carries one item per
// transaction: a tick (command 0) or a start command (1..4). a start is
// taken only while idle; a start while busy is dropped without effect.
// every accepted item yields exactly one result on the output channel
// (out_valid/out_ready): line levels, busy, done and the read words.
// delay_ticks is written through cfg_we/cfg_data; the user must do so
// only while idle, which the block does not enforce; 0 acts as 1.
// a result is valid in the cycle after acceptance. throughput: one
// item per cycle while results are taken; the sequencer state and the
// result register update in the same edge, so the single-entry output
// register sets the rate. when the receiver stalls, the result is held
// and in_ready falls until taken (in_ready = !out_valid | out_ready).
// at reset the sequencer's line state is high, it is idle and no result is pending.
`default_nettype none
module i2c_register_master_top
	import i2c_rm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [DELAY_W-1:0] cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         command,
	input  wire logic [6:0]         device_address,
	input  wire logic [7:0]         register_address,
	input  wire logic [7:0]         write_data,
	input  wire logic               sda_in,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    scl_level,
	output logic                    sda_release,
	output logic                    busy_res,
	output logic                    done_res,
	output logic signed [15:0]      first_word,
	output logic signed [15:0]      second_word
);
	logic [DELAY_W-1:0] delay_ticks_q, delay_cnt_q, delay_cnt_d;
	phase_t             phase_q, phase_d;
	logic [3:0]         bit_cnt_q, bit_cnt_d, byte_idx_q, byte_idx_d;
	logic [7:0]         shift_q, shift_d;
	logic [2:0]         lcmd_q;
	logic [6:0]         ldev_q;
	logic [7:0]         lreg_q, ldata_q;
	logic [15:0]        word_a_q, word_a_d, word_b_q, word_b_d;
	logic               scl_q, scl_d, sda_q, sda_d;
	logic               accept, is_start, done_d;
	logic [2:0]         lcmd_d;
	logic [6:0]         ldev_d;
	logic [7:0]         lreg_d, ldata_d;

	function automatic logic [3:0] nrecv_of(input logic [2:0] c);
		unique case (c)
			CMD_RD1: nrecv_of = 4'd1;
			CMD_RD2: nrecv_of = 4'd2;
			CMD_RD6: nrecv_of = 4'd6;
			default: nrecv_of = 4'd0;
		endcase
	endfunction

	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;
	assign is_start = (command == CMD_WRITE) || (command == CMD_RD1) ||
		(command == CMD_RD2) || (command == CMD_RD6);

	// sequencer next state, one step per accepted item
	always_comb begin
		logic [DELAY_W-1:0] unit;
		logic [3:0]         nrecv, bi, k;
		logic [7:0]         b;
		logic               adv, nxt;
		phase_t             ent;
		logic               do_ent;
		unit = (delay_ticks_q == '0) ? DELAY_W'(1) : delay_ticks_q;
		phase_d = phase_q; delay_cnt_d = delay_cnt_q; bit_cnt_d = bit_cnt_q;
		byte_idx_d = byte_idx_q; shift_d = shift_q; word_a_d = word_a_q;
		word_b_d = word_b_q; scl_d = scl_q; sda_d = sda_q; done_d = 1'b0;
		lcmd_d = lcmd_q; ldev_d = ldev_q; lreg_d = lreg_q; ldata_d = ldata_q;
		adv = 1'b0; nxt = 1'b0; ent = PH_IDLE; do_ent = 1'b0;
		b = '0; k = '0; nrecv = '0; bi = '0;
		if (is_start) begin
			if (phase_q == PH_IDLE) begin
				lcmd_d = command; ldev_d = device_address;
				lreg_d = register_address; ldata_d = write_data;
				word_a_d = '0; word_b_d = '0; byte_idx_d = '0;
				delay_cnt_d = '0; nxt = 1'b1;
			end
		end else if (phase_q != PH_IDLE) begin
			if (delay_cnt_q + DELAY_W'(1) >= unit) begin
				delay_cnt_d = '0; adv = 1'b1;
			end else begin
				delay_cnt_d = delay_cnt_q + DELAY_W'(1);
			end
		end
		// one bus unit ends
		if (adv) begin
			unique case (phase_q)
				PH_ST7, PH_MA3: begin
					byte_idx_d = byte_idx_q + 4'd1; nxt = 1'b1;
				end
				PH_TA2: begin
					scl_d = 1'b0; byte_idx_d = byte_idx_q + 4'd1; nxt = 1'b1;
				end
				PH_TXH: begin
					shift_d = {shift_q[6:0], 1'b0};
					bit_cnt_d = bit_cnt_q + 4'd1;
					ent = (bit_cnt_q + 4'd1 >= 4'd8) ? PH_TA0 : PH_TXL;
					do_ent = 1'b1;
				end
				PH_RXH: begin
					b = {shift_q[6:0], sda_in};
					shift_d = b;
					bit_cnt_d = bit_cnt_q + 4'd1;
					if (bit_cnt_q + 4'd1 >= 4'd8) begin
						k = byte_idx_q - 4'd5;
						if (lcmd_q == CMD_RD1) begin
							if (k == 4'd0) word_a_d = {8'd0, b};
						end else begin
							if (k == 4'd0) word_a_d[15:8] = b;
							else if (k == 4'd1) word_a_d[7:0] = b;
							else if (k == 4'd4) word_b_d[15:8] = b;
							else if (k == 4'd5) word_b_d[7:0] = b;
						end
						scl_d = 1'b0; ent = PH_MA0;
					end else begin
						ent = PH_RXL;
					end
					do_ent = 1'b1;
				end
				PH_SP5: begin
					phase_d = PH_IDLE; done_d = 1'b1;
				end
				PH_IDLE: phase_d = PH_IDLE;
				default: begin
					ent = phase_t'(phase_q + 5'd1); do_ent = 1'b1;
				end
			endcase
		end
		// begin the next item of the transaction
		if (nxt) begin
			bi = byte_idx_d;
			unique case (lcmd_d)
				CMD_RD1: nrecv = 4'd1;
				CMD_RD2: nrecv = 4'd2;
				CMD_RD6: nrecv = 4'd6;
				default: nrecv = 4'd0;
			endcase
			bit_cnt_d = '0; do_ent = 1'b1;
			if (lcmd_d == CMD_WRITE) begin
				if (bi == 4'd0) ent = PH_ST0;
				else if (bi <= 4'd3) ent = PH_TXL;
				else ent = PH_SP0;
			end else begin
				if (bi == 4'd0 || bi == 4'd3) ent = PH_ST0;
				else if (bi <= 4'd4) ent = PH_TXL;
				else if ({1'b0, bi} < 5'd5 + {1'b0, nrecv}) ent = PH_RXL;
				else ent = PH_SP0;
			end
			if (ent == PH_TXL) begin
				if (bi == 4'd1) shift_d = {ldev_d, 1'b0};
				else if (bi == 4'd2) shift_d = lreg_d;
				else if (bi == 4'd4) shift_d = {ldev_d, 1'b1};
				else shift_d = ldata_d;
			end else if (ent == PH_RXL) begin
				shift_d = '0;
			end
		end
		// line levels on entering a phase
		if (do_ent) begin
			phase_d = ent;
			unique case (ent)
				PH_ST2, PH_ST3: begin scl_d = 1'b1; sda_d = 1'b1; end
				PH_ST4, PH_ST5: sda_d = 1'b0;
				PH_ST6, PH_ST7: scl_d = 1'b0;
				PH_TXL: begin scl_d = 1'b0; sda_d = shift_d[7]; end
				PH_TXH, PH_TA2, PH_RXH, PH_MA2: scl_d = 1'b1;
				PH_TA0, PH_MA0, PH_MA3: scl_d = 1'b0;
				PH_TA1: sda_d = 1'b1;
				PH_RXL: begin scl_d = 1'b0; sda_d = 1'b1; end
				PH_MA1: sda_d = (byte_idx_d == 4'd4 + nrecv_of(lcmd_d));
				PH_SP0, PH_SP1: begin scl_d = 1'b0; sda_d = 1'b0; end
				PH_SP2, PH_SP3: scl_d = 1'b1;
				PH_SP4, PH_SP5: sda_d = 1'b1;
				default: ;
			endcase
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) delay_ticks_q <= DELAY_RESET;
		else if (cfg_we) delay_ticks_q <= cfg_data;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; delay_cnt_q <= '0; bit_cnt_q <= '0;
			byte_idx_q <= '0; shift_q <= '0; lcmd_q <= '0; ldev_q <= '0;
			lreg_q <= '0; ldata_q <= '0; word_a_q <= '0; word_b_q <= '0;
			scl_q <= 1'b1; sda_q <= 1'b1;
		end else if (accept) begin
			phase_q <= phase_d; delay_cnt_q <= delay_cnt_d; bit_cnt_q <= bit_cnt_d;
			byte_idx_q <= byte_idx_d; shift_q <= shift_d; lcmd_q <= lcmd_d;
			ldev_q <= ldev_d; lreg_q <= lreg_d; ldata_q <= ldata_d;
			word_a_q <= word_a_d; word_b_q <= word_b_d;
			scl_q <= scl_d; sda_q <= sda_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (accept) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			scl_level   <= scl_d;
			sda_release <= sda_d;
			busy_res    <= (phase_d != PH_IDLE);
			done_res    <= done_d;
			first_word  <= done_d ? word_a_d : 16'sd0;
			second_word <= done_d ? word_b_d : 16'sd0;
		end
	end

	// a done result always reports an idle sequencer
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res) else $error("done while busy");
	// a stalled result is held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(done_res))
		else $error("result dropped");
	// bit counter never passes one byte
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q <= 4'd8) else $error("bit count overrun");
endmodule
`default_nettype wire
